// ----- hw/rtl/three_level_priority_task_queue_core_defines.svh -----
// Assertion macros used by the checker file of the task queue core.
`ifndef THREE_LEVEL_PRIORITY_TASK_QUEUE_CORE_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_TASK_QUEUE_CORE_DEFINES_SVH

// Property that must hold at every rising clock edge outside reset.
`define TLPQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define TLPQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hw/rtl/tlpq_pkg.sv -----
// Types and constants of the three-level priority task queue.
package tlpq_pkg;

  localparam int ID_W  = 8;
  localparam int LVL_W = 2;
  localparam int OP_W  = 3;
  localparam int ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CANCEL = 3'd3,
    OP_ALL    = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2,
    ST_BUSY = 2'd3
  } status_e;

  // Broadcast from the controller to every cell of one level.
  typedef struct packed {
    logic            pop;
    logic            cancel;
    logic            append;
    logic            drain;
    logic [ID_W-1:0] id;
  } cell_ctrl_t;

  // Summary of one level reported back to the controller.
  typedef struct packed {
    logic            nonempty;
    logic            second;
    logic            full;
    logic            hit;
    logic [ID_W-1:0] front_id;
    logic [ID_W-1:0] tail_id;
  } row_stat_t;

endpackage

// ----- hw/rtl/tlpq_if.sv -----
// Request and result channel interfaces of the task queue core.
interface tlpq_req_if import tlpq_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [ID_W-1:0]  task_id;
  logic [LVL_W-1:0] level;

  modport source (output valid, op, task_id, level, input ready);
  modport sink (input valid, op, task_id, level, output ready);
endinterface

interface tlpq_rsp_if import tlpq_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  out_id;
  logic [LVL_W-1:0] out_level;
  logic [ST_W-1:0]  status;
  logic             last;

  modport source (output valid, out_id, out_level, status, last, input ready);
  modport sink (input valid, out_id, out_level, status, last, output ready);
endinterface

// ----- hw/rtl/tlpq_cell.sv -----
// One queue slot: holds an id, compares it and shifts toward the front.
module tlpq_cell import tlpq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic            carry_i,
  output logic            carry_o,
  input  logic            prev_valid_i,
  input  logic [ID_W-1:0] nbr_id_i,
  input  logic            nbr_valid_i,
  output logic [ID_W-1:0] id_o,
  output logic            valid_o,
  output logic            match_o,
  output logic            tail_o
);

  logic            valid_q, valid_d;
  logic [ID_W-1:0] id_q, id_d;
  logic            take, write, drop;

  assign match_o = valid_q && (id_q == ctrl_i.id);
  assign tail_o  = valid_q && !nbr_valid_i;
  // Once a removal point is passed, every later slot takes its neighbor.
  assign take    = carry_i || (ctrl_i.cancel && match_o);
  assign carry_o = take;
  assign write   = ctrl_i.append && !valid_q && prev_valid_i;
  assign drop    = ctrl_i.drain && tail_o;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    if (take) begin
      valid_d = nbr_valid_i;
      id_d    = nbr_id_i;
    end else if (write) begin
      valid_d = 1'b1;
      id_d    = ctrl_i.id;
    end else if (drop) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o    = id_q;
  assign valid_o = valid_q;

endmodule

// ----- hw/rtl/tlpq_row.sv -----
// One priority level: a chain of slot cells, front at cell zero.
module tlpq_row import tlpq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  output row_stat_t  stat_o
);

  logic [ID_W-1:0] ids   [DEPTH];
  logic [ID_W-1:0] nbr_id[DEPTH];
  logic [DEPTH-1:0] valid, nbr_valid, prev_valid, match, tail;
  logic [DEPTH:0]   carry;
  logic [ID_W-1:0]  tail_id;

  assign carry[0] = ctrl_i.pop;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_end
      assign nbr_id[i]    = '0;
      assign nbr_valid[i] = 1'b0;
    end else begin : g_mid
      assign nbr_id[i]    = ids[i+1];
      assign nbr_valid[i] = valid[i+1];
    end
    if (i == 0) begin : g_head
      assign prev_valid[i] = 1'b1;
    end else begin : g_body
      assign prev_valid[i] = valid[i-1];
    end

    tlpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .carry_i      (carry[i]),
      .carry_o      (carry[i+1]),
      .prev_valid_i (prev_valid[i]),
      .nbr_id_i     (nbr_id[i]),
      .nbr_valid_i  (nbr_valid[i]),
      .id_o         (ids[i]),
      .valid_o      (valid[i]),
      .match_o      (match[i]),
      .tail_o       (tail[i])
    );
  end

  // At most one cell is the tail.
  always_comb begin
    tail_id = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_id = tail_id | (ids[i] & {ID_W{tail[i]}});
    end
  end

  assign stat_o.nonempty = valid[0];
  assign stat_o.second   = valid[1];
  assign stat_o.full     = valid[DEPTH-1];
  assign stat_o.hit      = |match;
  assign stat_o.front_id = ids[0];
  assign stat_o.tail_id  = tail_id;

endmodule

// ----- hw/rtl/three_level_priority_task_queue_core.sv -----
// Top level: one result register, level selection and drain sequencing.
// An accepted request loads the output register, so its result is shown in the next cycle;
// a non-empty cancel-all first sets the drain state, then loads each id when the register is free.
// Append, pop, peek and cancel are accepted back to back while results are taken.
// Cancel-all returns its queued ids one result at a time; input is held off meanwhile.
// Reset clears every slot's valid bit at once; no clearing pass is needed.
module three_level_priority_task_queue_core import tlpq_pkg::*; #(
  parameter int NUM_LEVELS  = 3,
  parameter int LEVEL_DEPTH = 16,
  parameter int NUM_IDS     = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tlpq_req_if.sink  in_i,
  tlpq_rsp_if.source out_o
);

  cell_ctrl_t ctrl [NUM_LEVELS];
  row_stat_t  stat [NUM_LEVELS];

  logic [NUM_LEVELS-1:0] nonempty, hi_sel, lo_sel, hit, tgt, full;
  logic             acc, slot_free, drain_step, any_ne, found, busy, tgt_full;
  logic             id_ok, lvl_ok, app_ok, lo_last;
  logic [ID_W-1:0]  hi_id, lo_id;
  logic [LVL_W-1:0] hi_lvl, lo_lvl, hit_lvl;

  logic             drain_q, drain_d;
  logic             out_valid_q, out_valid_d;
  logic             load;
  logic [ID_W-1:0]  res_id_q, res_id_d;
  logic [LVL_W-1:0] res_lvl_q, res_lvl_d;
  status_e          res_st_q, res_st_d;
  logic             res_last_q, res_last_d;

  for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_row
    tlpq_row #(.DEPTH(LEVEL_DEPTH)) u_row (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[l]),
      .stat_o (stat[l])
    );
    assign nonempty[l] = stat[l].nonempty;
    assign hit[l]      = stat[l].hit;
    assign full[l]     = stat[l].full;
    assign tgt[l]      = (32'(in_i.level) == l);
  end

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = !drain_q && slot_free;
  assign acc        = in_i.valid && in_i.ready;
  assign drain_step = drain_q && slot_free;

  // Pick the highest non-empty level for pop and peek, the lowest for drain.
  always_comb begin
    logic seen_hi, seen_lo;
    seen_hi = 1'b0;
    seen_lo = 1'b0;
    hi_sel  = '0;
    lo_sel  = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      hi_sel[l] = nonempty[l] && !seen_hi;
      seen_hi   = seen_hi || nonempty[l];
    end
    for (int l = 0; l < NUM_LEVELS; l++) begin
      lo_sel[l] = nonempty[l] && !seen_lo;
      seen_lo   = seen_lo || nonempty[l];
    end
  end

  always_comb begin
    hi_id   = '0;
    hi_lvl  = '0;
    lo_id   = '0;
    lo_lvl  = '0;
    hit_lvl = '0;
    lo_last = 1'b0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (hi_sel[l]) begin
        hi_id  = stat[l].front_id;
        hi_lvl = LVL_W'(l);
      end
      if (lo_sel[l]) begin
        lo_id   = stat[l].tail_id;
        lo_lvl  = LVL_W'(l);
        lo_last = !stat[l].second;
      end
      if (hit[l]) begin
        hit_lvl = LVL_W'(l);
      end
    end
    // The drained entry is the final one only if no other level holds ids.
    lo_last = lo_last && (nonempty == lo_sel);
  end

  assign any_ne   = |nonempty;
  assign found    = |hit;
  assign busy     = found;
  assign tgt_full = |(tgt & full);
  assign id_ok    = (32'(in_i.task_id) < NUM_IDS);
  assign lvl_ok   = (32'(in_i.level) < NUM_LEVELS);
  assign app_ok   = id_ok && lvl_ok && !busy && !tgt_full;

  for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_ctrl
    assign ctrl[l].pop    = acc && (in_i.op == OP_POP) && hi_sel[l];
    assign ctrl[l].cancel = acc && (in_i.op == OP_CANCEL);
    assign ctrl[l].append = acc && (in_i.op == OP_APPEND) && app_ok && tgt[l];
    assign ctrl[l].drain  = drain_step && lo_sel[l];
    assign ctrl[l].id     = in_i.task_id;
  end

  always_comb begin
    load       = 1'b0;
    drain_d    = drain_q;
    res_id_d   = res_id_q;
    res_lvl_d  = res_lvl_q;
    res_st_d   = res_st_q;
    res_last_d = res_last_q;
    if (acc) begin
      res_last_d = 1'b1;
      unique case (in_i.op)
        OP_APPEND: begin
          load      = 1'b1;
          res_id_d  = in_i.task_id;
          res_lvl_d = in_i.level;
          if (!id_ok || !lvl_ok) begin
            res_st_d = ST_NONE;
          end else if (busy) begin
            res_st_d = ST_BUSY;
          end else if (tgt_full) begin
            res_st_d = ST_FULL;
          end else begin
            res_st_d = ST_OK;
          end
        end
        OP_POP, OP_PEEK: begin
          load      = 1'b1;
          res_id_d  = any_ne ? hi_id : '0;
          res_lvl_d = any_ne ? hi_lvl : '0;
          res_st_d  = any_ne ? ST_OK : ST_NONE;
        end
        OP_CANCEL: begin
          load      = 1'b1;
          res_id_d  = in_i.task_id;
          res_lvl_d = found ? hit_lvl : '0;
          res_st_d  = found ? ST_OK : ST_NONE;
        end
        OP_ALL: begin
          if (any_ne) begin
            drain_d = 1'b1;
          end else begin
            load      = 1'b1;
            res_id_d  = '0;
            res_lvl_d = '0;
            res_st_d  = ST_NONE;
          end
        end
        default: begin
          // Drop unused op codes without a result.
        end
      endcase
    end else if (drain_step) begin
      load       = 1'b1;
      res_id_d   = lo_id;
      res_lvl_d  = lo_lvl;
      res_st_d   = ST_OK;
      res_last_d = lo_last;
      drain_d    = !lo_last;
    end
    out_valid_d = load || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_id_q   <= res_id_d;
      res_lvl_q  <= res_lvl_d;
      res_st_q   <= res_st_d;
      res_last_q <= res_last_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_id    = res_id_q;
  assign out_o.out_level = res_lvl_q;
  assign out_o.status    = res_st_q;
  assign out_o.last      = res_last_q;

endmodule

// ----- hw/rtl/tlpq_checker.sv -----
// Port-level checks of the task queue core and their bind to the top level.
`include "three_level_priority_task_queue_core_defines.svh"

module tlpq_checker import tlpq_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic [OP_W-1:0] in_op_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [ST_W-1:0] out_status_i,
  input logic            out_last_i
);

  `TLPQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped before it was taken")
  `TLPQ_ASSERT(a_no_accept_on_stall, clk_i, rst_ni, !(out_valid_i && !out_ready_i && in_ready_i), "request taken while result is stalled")
  `TLPQ_ASSERT_NEXT(a_single_result, clk_i, rst_ni, in_valid_i && in_ready_i && (in_op_i == OP_APPEND || in_op_i == OP_POP || in_op_i == OP_PEEK || in_op_i == OP_CANCEL), out_valid_i && out_last_i, "single-result request gave no final result")
  `TLPQ_ASSERT(a_error_is_last, clk_i, rst_ni, !(out_valid_i && out_status_i != ST_OK && !out_last_i), "error result not marked last")

endmodule

bind three_level_priority_task_queue_core tlpq_checker u_tlpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.op),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_last_i   (out_o.last)
);

// ----- dv/three_level_priority_task_queue_core_tb.sv -----
// Self-checking testbench for the three-level priority task queue core.
`timescale 1ns / 100ps

module three_level_priority_task_queue_core_tb;
  import tlpq_pkg::*;

  localparam int NUM_LEVELS   = 3;
  localparam int LEVEL_DEPTH  = 16;
  localparam int NUM_IDS      = 256;
  localparam int RANDOM_ITEMS = 280;
  localparam int IDLE_PCT     = 23;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_REPORTS  = 60;

  // Op codes the block ignores.
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;
  // Level code beyond the last level.
  localparam logic [LVL_W-1:0] LVL_MISSING = 2'd3;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] lvl;
    bit               wait_drain;
  } task_req_t;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] lvl;
    status_e          st;
    logic             last;
  } task_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tlpq_req_if req_if ();
  tlpq_rsp_if rsp_if ();

  three_level_priority_task_queue_core #(
    .NUM_LEVELS (NUM_LEVELS),
    .LEVEL_DEPTH(LEVEL_DEPTH),
    .NUM_IDS    (NUM_IDS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the queue contents and busy marks.
  logic [ID_W-1:0] lvl_fifo [NUM_LEVELS][$];
  bit              busy_ids [NUM_IDS];

  task_req_t pending_reqs[$];
  task_rsp_t owed_rsps[$];

  bit req_taken;
  bit rsp_taken;
  int fail_cnt;
  int idle_cycles;
  int n_presented;

  task automatic flag_mismatch(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic add_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                         input logic [LVL_W-1:0] lvl);
    task_req_t t;
    t.op = op;
    t.id = id;
    t.lvl = lvl;
    t.wait_drain = 1'b0;
    pending_reqs.push_back(t);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    // Favor a small pool so that ids collide with queued ones.
    if ($urandom_range(1) == 1) return ID_W'($urandom_range(31));
    return ID_W'($urandom_range(NUM_IDS - 1));
  endfunction

  // Apply one accepted transaction to the shadow state and queue its results.
  function automatic void apply_task_op(input logic [OP_W-1:0] op,
                                        input logic [ID_W-1:0] id,
                                        input logic [LVL_W-1:0] lvl);
    task_rsp_t drained[$];
    task_rsp_t r;
    int top;
    int l;
    int p;
    bit found;
    logic [ID_W-1:0] v;
    r.id = id;
    r.lvl = lvl;
    r.st = ST_OK;
    r.last = 1'b1;
    found = 1'b0;
    case (op)
      OP_APPEND: begin
        if (lvl >= NUM_LEVELS) r.st = ST_NONE;
        else if (busy_ids[id]) r.st = ST_BUSY;
        else if (lvl_fifo[lvl].size() >= LEVEL_DEPTH) r.st = ST_FULL;
        else begin
          lvl_fifo[lvl].push_back(id);
          busy_ids[id] = 1'b1;
        end
        owed_rsps.push_back(r);
      end
      OP_POP, OP_PEEK: begin
        top = -1;
        for (l = 0; l < NUM_LEVELS; l++) if (lvl_fifo[l].size() != 0) top = l;
        if (top < 0) begin
          r.id = '0;
          r.lvl = '0;
          r.st = ST_NONE;
        end else begin
          r.id = lvl_fifo[top][0];
          r.lvl = LVL_W'(top);
          if (op == OP_POP) begin
            void'(lvl_fifo[top].pop_front());
            busy_ids[r.id] = 1'b0;
          end
        end
        owed_rsps.push_back(r);
      end
      OP_CANCEL: begin
        r.lvl = '0;
        r.st = ST_NONE;
        // Search lowest level first, front to back.
        for (l = 0; l < NUM_LEVELS && !found; l++) begin
          for (p = 0; p < lvl_fifo[l].size() && !found; p++) begin
            if (lvl_fifo[l][p] == id) begin
              lvl_fifo[l].delete(p);
              busy_ids[id] = 1'b0;
              r.lvl = LVL_W'(l);
              r.st = ST_OK;
              found = 1'b1;
            end
          end
        end
        owed_rsps.push_back(r);
      end
      OP_ALL: begin
        // Drain lowest level first, each from the back.
        for (l = 0; l < NUM_LEVELS; l++) begin
          while (lvl_fifo[l].size() != 0) begin
            v = lvl_fifo[l].pop_back();
            busy_ids[v] = 1'b0;
            r.id = v;
            r.lvl = LVL_W'(l);
            r.st = ST_OK;
            r.last = 1'b0;
            drained.push_back(r);
          end
        end
        if (drained.size() == 0) begin
          r.id = '0;
          r.lvl = '0;
          r.st = ST_NONE;
          r.last = 1'b1;
          drained.push_back(r);
        end else begin
          drained[drained.size() - 1].last = 1'b1;
        end
        foreach (drained[i]) owed_rsps.push_back(drained[i]);
      end
      default: ;
    endcase
  endfunction

  // Sample both channels, predict, check, and watch for a hang.
  always @(posedge clk_i) begin
    task_rsp_t exp_rsp;
    req_taken = 1'b0;
    rsp_taken = 1'b0;
    if (rst_ni) begin
      req_taken = req_if.valid && req_if.ready;
      rsp_taken = rsp_if.valid && rsp_if.ready;
      if (req_taken) apply_task_op(req_if.op, req_if.task_id, req_if.level);
      if (rsp_taken) begin
        if (owed_rsps.size() == 0) begin
          flag_mismatch($sformatf("unexpected result id=%0h lvl=%0d st=%0d last=%0b",
                                  rsp_if.out_id, rsp_if.out_level, rsp_if.status,
                                  rsp_if.last));
        end else begin
          exp_rsp = owed_rsps.pop_front();
          if (rsp_if.out_id !== exp_rsp.id || rsp_if.out_level !== exp_rsp.lvl ||
              rsp_if.status !== exp_rsp.st || rsp_if.last !== exp_rsp.last) begin
            flag_mismatch($sformatf(
              "got id=%0h lvl=%0d st=%0d last=%0b, want id=%0h lvl=%0d st=%0d last=%0b",
              rsp_if.out_id, rsp_if.out_level, rsp_if.status, rsp_if.last,
              exp_rsp.id, exp_rsp.lvl, exp_rsp.st, exp_rsp.last));
          end
        end
      end
      if (req_taken || rsp_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Drive requests and result backpressure at the falling edge.
  always @(negedge clk_i) begin
    task_req_t nxt;
    bit nxt_valid;
    bit calm;
    if (rst_ni) begin
      calm = (n_presented >= 120 && n_presented < 190);
      nxt_valid = req_if.valid && !req_taken;
      if (!nxt_valid && pending_reqs.size() != 0) begin
        if (pending_reqs[0].wait_drain && owed_rsps.size() != 0) begin
          // hold until every owed result is out
        end else if (calm || $urandom_range(99) >= IDLE_PCT) begin
          nxt = pending_reqs.pop_front();
          req_if.op <= nxt.op;
          req_if.task_id <= nxt.id;
          req_if.level <= nxt.lvl;
          nxt_valid = 1'b1;
          n_presented++;
        end
      end
      req_if.valid <= nxt_valid;
      rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    int kind;
    int len;
    int n_real;
    int c;
    logic [LVL_W-1:0] lv;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] recent_ids[$];

    req_if.valid = 1'b0;
    req_if.op = '0;
    req_if.task_id = '0;
    req_if.level = '0;
    rsp_if.ready = 1'b0;

    // Empty-queue cases first.
    add_req(OP_POP, 8'h00, 2'd0);
    add_req(OP_PEEK, 8'h00, 2'd0);
    add_req(OP_ALL, 8'h00, 2'd0);
    add_req(OP_CANCEL, 8'hA5, 2'd0);
    add_req(OP_APPEND, 8'hFF, LVL_MISSING);
    add_req(OP_APPEND, 8'h00, 2'd0);
    add_req(OP_APPEND, 8'hFF, 2'd2);
    add_req(OP_APPEND, 8'h80, 2'd1);
    add_req(OP_APPEND, 8'h7F, 2'd0);
    add_req(OP_APPEND, 8'h00, 2'd1);
    add_req(OP_PEEK, 8'h00, 2'd0);
    add_req(OP_POP, 8'h00, 2'd0);
    add_req(OP_POP, 8'h00, 2'd0);
    add_req(OP_CANCEL, 8'h00, 2'd0);
    add_req(OP_APPEND, 8'h55, 2'd2);
    add_req(OP_APPEND, 8'h2A, 2'd1);
    for (c = OP_FIRST_UNUSED; c <= OP_LAST_UNUSED; c++) add_req(OP_W'(c), 8'hFF, 2'd3);
    add_req(OP_ALL, 8'h00, 2'd0);
    add_req(OP_CANCEL, 8'h7F, 2'd0);
    pending_reqs[pending_reqs.size() - 1].wait_drain = 1'b1;

    n_real = 0;
    while (n_real < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 38) begin
        // fill one level, often past full
        lv = LVL_W'($urandom_range(NUM_LEVELS - 1));
        len = $urandom_range(3, LEVEL_DEPTH + 2);
        repeat (len) begin
          id = pick_id();
          add_req(OP_APPEND, id, lv);
          recent_ids.push_back(id);
          if (recent_ids.size() > 32) void'(recent_ids.pop_front());
        end
        n_real += len;
      end else if (kind < 63) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          op = ($urandom_range(1) == 1) ? OP_POP : OP_PEEK;
          add_req(op, pick_id(), LVL_W'($urandom_range(3)));
        end
        n_real += len;
      end else if (kind < 80) begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          if (recent_ids.size() != 0 && $urandom_range(3) != 0)
            id = recent_ids[$urandom_range(recent_ids.size() - 1)];
          else
            id = pick_id();
          add_req(OP_CANCEL, id, LVL_W'($urandom_range(3)));
        end
        n_real += len;
      end else if (kind < 88) begin
        add_req(OP_ALL, pick_id(), LVL_W'($urandom_range(3)));
        n_real++;
      end else begin
        op = OP_W'($urandom_range(OP_LAST_UNUSED));
        add_req(op, ID_W'($urandom_range(NUM_IDS - 1)), LVL_W'($urandom_range(3)));
        if (op <= OP_ALL) n_real++;
      end
    end
    pending_reqs[pending_reqs.size() / 2].wait_drain = 1'b1;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || req_if.valid) @(posedge clk_i);
    while (owed_rsps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- three_level_priority_task_queue_core.f -----
+incdir+hw/rtl
hw/rtl/tlpq_pkg.sv
hw/rtl/tlpq_if.sv
hw/rtl/tlpq_cell.sv
hw/rtl/tlpq_row.sv
hw/rtl/three_level_priority_task_queue_core.sv
hw/rtl/tlpq_checker.sv
dv/three_level_priority_task_queue_core_tb.sv
